// ===== rtl/tlca_pkg.sv =====
// shared types and constants for the lowest common ancestor unit
// no dependencies
package tlca_pkg;
    localparam int MaxNodes = 1024;
    localparam int Levels   = 11;
    localparam int NodeW    = $clog2(MaxNodes);
    localparam int CountW   = NodeW + 1;
    localparam int LevelW   = $clog2(Levels + 1);
    localparam int TableW   = $clog2(Levels * MaxNodes);

    localparam logic CmdLoad  = 1'b0;
    localparam logic CmdQuery = 1'b1;

    // table entry: absent flag and node
    typedef struct packed {
        logic             absent;
        logic [NodeW-1:0] node;
    } t_entry;

    typedef struct packed {
        logic             cmd;
        logic [NodeW-1:0] node_a;
        logic [NodeW-1:0] node_b;
        logic             is_root;
        logic             last_load;
    } t_in_item;

    typedef struct packed {
        logic [NodeW-1:0] ancestor;
        logic             bad_index;
    } t_out_item;

    // flat table address of level k, node v
    function automatic logic [TableW-1:0] tab_addr(input logic [LevelW-1:0] k,
                                                   input logic [NodeW-1:0] v);
        tab_addr = TableW'({k, v});
    endfunction
endpackage

// ===== rtl/tlca_stream_if.sv =====
// valid/ready channel carrying one transaction payload
// no dependencies
interface tlca_stream_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/tlca_ram.sv =====
// single port synchronous ram with registered read data
// no dependencies
module tlca_ram #(
    parameter int Width = 8,
    parameter int AddrW = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_addr,
    input  logic [Width-1:0] i_wdata,
    output logic [Width-1:0] o_rdata
);
    logic [Width-1:0] r_mem [2**AddrW];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== rtl/tree_lca_binary_lifting_unit.sv =====
// lowest common ancestor unit: ancestor-table ram, depth ram, sequencer
// a load writes one level 0 entry; the last load starts the build: level 0 cleanup, higher levels, then depths
// a query reads both depths, lifts the deeper node, descends the levels, then checks the level 0 parents
// one transaction in work at a time; a finished result waits in an output register
// reset: synchronous active low; empty tree, tables undefined until built
module tree_lca_binary_lifting_unit (
    input logic        i_clk,
    input logic        i_rst_n,
    tlca_stream_if.sink   i_in,
    tlca_stream_if.source o_out
);
    import tlca_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD,
        S_B0_RD, S_B0_WT, S_B0_WR,
        S_BK_RD, S_BK_WT, S_BK_RD2, S_BK_WT2, S_BK_WR,
        S_BD_RD, S_BD_WT, S_BD_WR,
        S_Q_D1, S_Q_D2, S_Q_D3,
        S_Q_L_RD, S_Q_L_WT,
        S_Q_U_RD, S_Q_U_WT, S_Q_V_RD, S_Q_V_WT, S_Q_U_STEP,
        S_Q_F_U, S_Q_F_UW, S_Q_F_V, S_Q_F_VW, S_DONE
    } t_state;

    t_state            r_state;
    t_in_item          r_item;
    logic [CountW-1:0] r_count;
    logic              r_ready_tab;
    logic [NodeW-1:0]  r_v, r_u, r_cur;
    logic [LevelW-1:0] r_k;
    logic [CountW-1:0] r_idx;
    t_entry            r_p, r_pu;
    logic [CountW+1:0] r_d;
    logic [NodeW-1:0]  r_diff, r_du;
    logic              r_oval;
    t_out_item         r_res;
    t_out_item         r_out;

    logic              tab_we;
    logic [TableW-1:0] tab_addr_s;
    t_entry            tab_wd, tab_rd;
    logic              dep_we;
    logic [NodeW-1:0]  dep_addr, dep_wd, dep_rd;

    tlca_ram #(.Width($bits(t_entry)), .AddrW(TableW)) u_tab (
        .i_clk(i_clk), .i_we(tab_we), .i_addr(tab_addr_s),
        .i_wdata(tab_wd), .o_rdata(tab_rd));

    tlca_ram #(.Width(NodeW), .AddrW(NodeW)) u_dep (
        .i_clk(i_clk), .i_we(dep_we), .i_addr(dep_addr),
        .i_wdata(dep_wd), .o_rdata(dep_rd));

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_oval;
    assign o_out.payload = r_out;

    logic [NodeW-1:0] idx_n;
    assign idx_n = r_idx[NodeW-1:0];

    // memory port drive by state
    always_comb begin
        tab_we = 1'b0; tab_addr_s = '0; tab_wd = '0;
        dep_we = 1'b0; dep_addr = '0; dep_wd = '0;
        unique case (r_state)
            S_LOAD: begin
                tab_we = 1'b1;
                tab_addr_s = tab_addr('0, r_item.node_a);
                tab_wd = r_item.is_root ? t_entry'{1'b1, '0}
                                        : t_entry'{1'b0, r_item.node_b};
            end
            S_B0_RD: tab_addr_s = tab_addr('0, idx_n);
            S_B0_WR: begin
                tab_we = 1'b1;
                tab_addr_s = tab_addr('0, idx_n);
                tab_wd = (r_p.absent || {1'b0, r_p.node} >= r_count)
                         ? t_entry'{1'b1, '0} : r_p;
            end
            S_BK_RD:  tab_addr_s = tab_addr(r_k, idx_n);
            S_BK_RD2: tab_addr_s = tab_addr(r_k, r_p.node);
            S_BK_WR: begin
                tab_we = 1'b1;
                tab_addr_s = tab_addr(r_k + LevelW'(1), idx_n);
                tab_wd = r_p.absent ? t_entry'{1'b1, '0} : r_pu;
            end
            S_BD_RD: tab_addr_s = tab_addr(r_k, r_cur);
            S_BD_WR: begin
                dep_we = 1'b1;
                dep_addr = idx_n;
                dep_wd = (r_d > (CountW+2)'(MaxNodes - 1)) ? NodeW'(MaxNodes - 1)
                                                           : r_d[NodeW-1:0];
            end
            S_Q_D1:   dep_addr = r_u;
            S_Q_D2:   dep_addr = r_v;
            S_Q_L_RD: tab_addr_s = tab_addr(r_k, r_v);
            S_Q_U_RD: tab_addr_s = tab_addr(r_k, r_u);
            S_Q_V_RD: tab_addr_s = tab_addr(r_k, r_v);
            S_Q_F_U:  tab_addr_s = tab_addr('0, r_u);
            S_Q_F_V:  tab_addr_s = tab_addr('0, r_v);
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_ready_tab <= 1'b0; r_oval <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in.valid && i_in.ready) begin
                    r_item <= i_in.payload;
                    if (i_in.payload.cmd == CmdLoad) begin
                        r_state <= S_LOAD;
                        if (r_ready_tab) begin
                            r_ready_tab <= 1'b0; r_count <= '0;
                        end
                    end else begin
                        r_res <= '{ancestor: '0, bad_index: 1'b1};
                        r_u <= i_in.payload.node_a; r_v <= i_in.payload.node_b;
                        if (!r_ready_tab || {1'b0, i_in.payload.node_a} >= r_count
                            || {1'b0, i_in.payload.node_b} >= r_count) begin
                            r_state <= S_DONE;
                        end else r_state <= S_Q_D1;
                    end
                end
                S_LOAD: begin
                    if ({1'b0, r_item.node_a} + CountW'(1) > r_count)
                        r_count <= {1'b0, r_item.node_a} + CountW'(1);
                    r_idx <= '0;
                    r_state <= r_item.last_load ? S_B0_RD : S_IDLE;
                end
                // level 0 cleanup
                S_B0_RD: r_state <= (r_idx >= r_count) ? S_BK_RD : S_B0_WT;
                S_B0_WT: begin r_p <= tab_rd; r_state <= S_B0_WR; end
                S_B0_WR: begin
                    r_idx <= r_idx + CountW'(1);
                    r_state <= S_B0_RD;
                    if (r_idx + CountW'(1) >= r_count) begin
                        r_idx <= '0; r_k <= '0;
                        r_state <= (Levels > 1) ? S_BK_RD : S_BD_RD;
                    end
                end
                // higher levels
                S_BK_RD: begin
                    if (r_idx >= r_count) begin
                        r_idx <= '0; r_k <= LevelW'(Levels - 1);
                        r_cur <= '0; r_d <= '0; r_state <= S_BD_RD;
                    end else r_state <= S_BK_WT;
                end
                S_BK_WT:  begin r_p <= tab_rd; r_state <= S_BK_RD2; end
                S_BK_RD2: r_state <= S_BK_WT2;
                S_BK_WT2: begin r_pu <= tab_rd; r_state <= S_BK_WR; end
                S_BK_WR: begin
                    r_idx <= r_idx + CountW'(1);
                    r_state <= S_BK_RD;
                    if (r_idx + CountW'(1) >= r_count) begin
                        r_idx <= '0;
                        if (r_k + LevelW'(2) < LevelW'(Levels)) r_k <= r_k + LevelW'(1);
                        else begin
                            r_k <= LevelW'(Levels - 1); r_cur <= '0; r_d <= '0;
                            r_state <= S_BD_RD;
                        end
                    end
                end
                // depth by descending jumps
                S_BD_RD: begin
                    if (r_idx >= r_count) begin
                        r_ready_tab <= 1'b1; r_state <= S_IDLE;
                    end else r_state <= S_BD_WT;
                end
                S_BD_WT: begin
                    if (!tab_rd.absent) begin
                        r_d <= r_d + ((CountW+2)'(1) << r_k);
                        r_cur <= tab_rd.node;
                    end
                    if (r_k == '0) r_state <= S_BD_WR;
                    else begin r_k <= r_k - LevelW'(1); r_state <= S_BD_RD; end
                end
                S_BD_WR: begin
                    r_idx <= r_idx + CountW'(1);
                    r_cur <= idx_n + NodeW'(1);
                    r_d <= '0; r_k <= LevelW'(Levels - 1);
                    r_state <= S_BD_RD;
                end
                // query: depths
                S_Q_D1: r_state <= S_Q_D2;
                S_Q_D2: begin r_du <= dep_rd; r_state <= S_Q_D3; end
                S_Q_D3: begin
                    if (r_du > dep_rd) begin
                        r_u <= r_v; r_v <= r_u; r_diff <= r_du - dep_rd;
                    end else r_diff <= dep_rd - r_du;
                    r_k <= '0; r_state <= S_Q_L_RD;
                end
                S_Q_L_RD: begin
                    if (r_k == LevelW'(Levels)) begin
                        if (r_u == r_v) begin
                            r_res <= '{ancestor: r_u, bad_index: 1'b0};
                            r_state <= S_DONE;
                        end else begin
                            r_k <= LevelW'(Levels - 1); r_state <= S_Q_U_RD;
                        end
                    end else if (r_diff[r_k[$clog2(NodeW)-1:0]] == 1'b0 || r_k >= LevelW'(NodeW))
                        r_k <= r_k + LevelW'(1);
                    else r_state <= S_Q_L_WT;
                end
                S_Q_L_WT: begin
                    if (!tab_rd.absent) r_v <= tab_rd.node;
                    r_k <= r_k + LevelW'(1); r_state <= S_Q_L_RD;
                end
                S_Q_U_RD: r_state <= S_Q_U_WT;
                S_Q_U_WT: begin r_pu <= tab_rd; r_state <= S_Q_V_RD; end
                S_Q_V_RD: r_state <= S_Q_V_WT;
                S_Q_V_WT: begin r_p <= tab_rd; r_state <= S_Q_U_STEP; end
                S_Q_U_STEP: begin
                    if (r_pu != r_p && !r_pu.absent && !r_p.absent) begin
                        r_u <= r_pu.node; r_v <= r_p.node;
                    end
                    if (r_k == '0) r_state <= S_Q_F_U;
                    else begin r_k <= r_k - LevelW'(1); r_state <= S_Q_U_RD; end
                end
                S_Q_F_U:  r_state <= S_Q_F_UW;
                S_Q_F_UW: begin r_pu <= tab_rd; r_state <= S_Q_F_V; end
                S_Q_F_V:  r_state <= S_Q_F_VW;
                S_Q_F_VW: begin
                    if (!r_pu.absent && r_pu == tab_rd)
                        r_res <= '{ancestor: r_pu.node, bad_index: 1'b0};
                    r_state <= S_DONE;
                end
                // hand the result over once the output register is free
                S_DONE: if (!r_oval || o_out.ready) begin
                    r_out <= r_res; r_oval <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a finished result waits while the previous one is still held
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && r_oval && !o_out.ready |=> r_state == S_DONE)
        else $error("result overrun");
    // a flagged result carries node zero
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval && r_out.bad_index |-> r_out.ancestor == '0) else $error("bad result");
    // a waiting result is not dropped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval && !o_out.ready |=> r_oval) else $error("result dropped");
endmodule

// ===== dv/tb_tree_lca_binary_lifting_unit.sv =====
`timescale 1ns / 100ps
// testbench for tree_lca_binary_lifting_unit: tree loads, builds and lca queries
// checked against a behavioral predictor; depends on tlca_pkg and tlca_stream_if
module tb_tree_lca_binary_lifting_unit;
    import tlca_pkg::*;

    localparam int CycleLimit = 1500000;

    // lca predictor and queue of expected answers
    class lca_scoreboard;
        t_entry           anc_tab [Levels][MaxNodes];
        logic [NodeW-1:0] depth_tab [MaxNodes];
        int               node_count;
        bit               built;
        t_out_item        answer_q [$];
        int               errors;

        function new();
            node_count = 0;
            built      = 0;
            errors     = 0;
        endfunction

        // level 0 cleanup, ancestor levels, then depths by jumping down from the top level
        function void build_tree();
            t_entry p;
            int     d;
            int     cur;
            for (int v = 0; v < node_count; v++) begin
                p = anc_tab[0][v];
                if (p.absent || p.node >= node_count) anc_tab[0][v] = '{1'b1, '0};
            end
            for (int k = 0; k + 1 < Levels; k++) begin
                for (int v = 0; v < node_count; v++) begin
                    p = anc_tab[k][v];
                    anc_tab[k+1][v] = p.absent ? t_entry'{1'b1, '0} : anc_tab[k][p.node];
                end
            end
            for (int v = 0; v < node_count; v++) begin
                d   = 0;
                cur = v;
                for (int l = Levels - 1; l >= 0; l--) begin
                    p = anc_tab[l][cur];
                    if (!p.absent) begin
                        d   += 1 << l;
                        cur  = p.node;
                    end
                end
                depth_tab[v] = (d > MaxNodes - 1) ? NodeW'(MaxNodes - 1) : NodeW'(d);
            end
            built = 1;
        endfunction

        function t_out_item lowest_ancestor(int a, int b);
            int     u;
            int     v;
            int     t;
            int     diff;
            t_entry pu;
            t_entry pv;
            if (!built || a >= node_count || b >= node_count) return '{'0, 1'b1};
            u = a;
            v = b;
            if (depth_tab[u] > depth_tab[v]) begin
                t = u; u = v; v = t;
            end
            diff = int'(depth_tab[v]) - int'(depth_tab[u]);
            for (int k = 0; k < Levels; k++) begin
                if (((diff >> k) & 1) && !anc_tab[k][v].absent) v = anc_tab[k][v].node;
            end
            if (u == v) return '{NodeW'(u), 1'b0};
            for (int k = Levels - 1; k >= 0; k--) begin
                pu = anc_tab[k][u];
                pv = anc_tab[k][v];
                if (pu != pv && !pu.absent && !pv.absent) begin
                    u = pu.node;
                    v = pv.node;
                end
            end
            pu = anc_tab[0][u];
            pv = anc_tab[0][v];
            if (!pu.absent && pu == pv) return '{pu.node, 1'b0};
            return '{'0, 1'b1};
        endfunction

        function void note_input(t_in_item it);
            if (it.cmd == CmdLoad) begin
                // a load after a build starts a new tree
                if (built) begin
                    built      = 0;
                    node_count = 0;
                end
                anc_tab[0][it.node_a] = it.is_root ? t_entry'{1'b1, '0}
                                                   : t_entry'{1'b0, it.node_b};
                if (int'(it.node_a) + 1 > node_count) node_count = int'(it.node_a) + 1;
                if (it.last_load) build_tree();
            end else begin
                answer_q.push_back(lowest_ancestor(it.node_a, it.node_b));
            end
        endfunction

        function void check_result(t_out_item r);
            t_out_item e;
            if (answer_q.size() == 0) begin
                $error("unexpected result: ancestor %0d bad_index %0d", r.ancestor, r.bad_index);
                errors++;
                return;
            end
            e = answer_q.pop_front();
            if (r.ancestor !== e.ancestor) begin
                $error("ancestor: expected %0d, actual %0d", e.ancestor, r.ancestor);
                errors++;
            end
            if (r.bad_index !== e.bad_index) begin
                $error("bad_index: expected %0d, actual %0d", e.bad_index, r.bad_index);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    tlca_stream_if #(.T(t_in_item))  in_if (i_clk);
    tlca_stream_if #(.T(t_out_item)) out_if (i_clk);

    tree_lca_binary_lifting_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    lca_scoreboard sb = new();
    int  cycles;
    bit  calm;
    int  rdy_hold;
    int  items_sent;
    int  parent_of [MaxNodes];
    bit  root_of [MaxNodes];
    int  load_order [MaxNodes];

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        out_if.ready  = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // cycle count, timeout and a slowly toggling no-idle mode
    always @(posedge i_clk) begin
        cycles++;
        if (cycles % 700 == 0) calm = ($urandom_range(0, 3) == 0);
        if (cycles > CycleLimit) begin
            $display("tb_tree_lca_binary_lifting_unit: errors");
            $finish;
        end
    end

    // accepted input transactions feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) sb.note_input(in_if.payload);
    end

    // accepted result transactions are checked
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.payload);
    end

    // receiver stalls: mostly short, a few long
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (rdy_hold > 0) begin
            rdy_hold--;
        end else if (calm || r < 65) begin
            out_if.ready <= 1'b1;
        end else if (r < 94) begin
            out_if.ready <= 1'b0;
            rdy_hold = $urandom_range(0, 3);
        end else begin
            out_if.ready <= 1'b0;
            rdy_hold = $urandom_range(10, 60);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send(t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        items_sent++;
    endtask

    task automatic load_node(int a, int b, bit root, bit last);
        send('{CmdLoad, NodeW'(a), NodeW'(b), root, last});
    endtask

    task automatic query(int a, int b);
        send('{CmdQuery, NodeW'(a), NodeW'(b), 1'b0, 1'b0});
    endtask

    // drop valid and let the last accepted query reach the queue before waiting for every answer
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.answer_q.size() != 0) @(posedge i_clk);
    endtask

    // random tree of n nodes loaded in shuffled order, with occasional noise
    task automatic load_random_tree(int n);
        int r;
        int t;
        int j;
        for (int v = 0; v < n; v++) begin
            r = $urandom_range(0, 99);
            root_of[v]   = (v == 0) || (r < 4);
            parent_of[v] = (v == 0) ? $urandom_range(0, 1023) : $urandom_range(0, v - 1);
            if (r >= 4 && r < 8) parent_of[v] = $urandom_range(n, 1023 > n ? 1023 : n);
            else if (r >= 8 && r < 11) parent_of[v] = $urandom_range(0, n - 1);
            if (parent_of[v] > 1023) parent_of[v] = 1023;
            load_order[v] = v;
        end
        for (int v = n - 1; v > 0; v--) begin
            j = $urandom_range(0, v);
            t = load_order[v]; load_order[v] = load_order[j]; load_order[j] = t;
        end
        for (int i = 0; i < n; i++) begin
            // stray query or rewrite while the tree is incomplete
            if ($urandom_range(0, 99) < 3) query($urandom_range(0, 1023), $urandom_range(0, 1023));
            if (i > 0 && $urandom_range(0, 99) < 2) begin
                t = load_order[$urandom_range(0, i - 1)];
                load_node(t, parent_of[t], root_of[t], 1'b0);
            end
            t = load_order[i];
            load_node(t, parent_of[t], root_of[t], i == n - 1);
        end
    endtask

    initial begin
        int n;
        int nq;
        int bigs;
        cycles     = 0;
        calm       = 0;
        rdy_hold   = 0;
        items_sent = 0;
        bigs       = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // query before any build
        query(0, 1023);
        // small tree with root ignoring its parent field
        load_node(0, 1023, 1'b1, 1'b0);
        query(0, 0);
        load_node(1, 0, 1'b0, 1'b0);
        load_node(2, 0, 1'b0, 1'b0);
        load_node(3, 1, 1'b0, 1'b0);
        load_node(4, 1, 1'b0, 1'b0);
        load_node(5, 2, 1'b0, 1'b1);
        query(3, 4);
        query(3, 5);
        query(3, 3);
        query(5, 0);
        query(6, 0);
        query(1023, 2);
        // new tree: parent out of range acts as a root, so two trees
        load_node(0, 0, 1'b1, 1'b0);
        load_node(1, 0, 1'b0, 1'b0);
        load_node(2, 1023, 1'b0, 1'b0);
        load_node(3, 2, 1'b0, 1'b1);
        query(1, 3);
        query(3, 2);
        // cyclic parent links
        load_node(0, 1, 1'b0, 1'b0);
        load_node(1, 0, 1'b0, 1'b0);
        load_node(2, 0, 1'b0, 1'b1);
        query(2, 1);
        query(0, 1);

        // hold off until every answer is back
        drain();

        // random trees and query bursts
        while (items_sent < 800) begin
            if (bigs < 1 && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(300, 500);
                bigs++;
            end else begin
                n = $urandom_range(1, 40);
            end
            load_random_tree(n);
            nq = $urandom_range(5, 30);
            for (int i = 0; i < nq; i++) begin
                if ($urandom_range(0, 99) < 85) query($urandom_range(0, n - 1), $urandom_range(0, n - 1));
                else query($urandom_range(0, 1023), $urandom_range(0, 1023));
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.answer_q.size() == 0) begin
            $display("tb_tree_lca_binary_lifting_unit: clean");
        end else begin
            $display("tb_tree_lca_binary_lifting_unit: errors");
        end
        $finish;
    end
endmodule
